### design/bma_pkg.sv
// ---------------------------------------------------------------------------
// bma_pkg: shared types and codes of the buddy memory allocator
// Node state codes of the block tree and result status codes.
// ---------------------------------------------------------------------------
package bma_pkg;

  typedef enum logic [1:0] {
    NODE_ABSENT = 2'd0,
    NODE_FREE   = 2'd1,
    NODE_ALLOC  = 2'd2,
    NODE_SPLIT  = 2'd3
  } node_st_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  localparam int unsigned CfgW    = 4;
  localparam int unsigned ReqW    = 11;
  localparam int unsigned AddrW   = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned DenyW   = 16;
  localparam int unsigned WantW   = 4;
  localparam int unsigned ResetOrder = 10;

endpackage

### design/buddy_memory_allocator.sv
// ---------------------------------------------------------------------------
// buddy_memory_allocator: binary buddy allocator over 2^total_order units
// Block tree kept in one node memory; each node holds its state and a mask
// of the free block sizes present in its subtree.
// ---------------------------------------------------------------------------
// Usage:
//   Input words (opcode, request_size, block_address) enter on in_valid
//   while in_stall is low; one result word per input leaves on out_valid,
//   held while out_stall is high. The block takes one word at a time; the
//   next one is taken while the previous result still waits at the output.
//   Allocate: accept, read the root mask, descend level by level to the
//   chosen free block, split it level by level down to the wanted size,
//   then walk back up to the root to refresh the size masks, and present.
//   Free: walk down to the block, then merge or update level by level up
//   to the root. A request larger than the memory or a free beyond it
//   goes straight to the result; a refusal from the root mask follows the
//   root read, and a free that finds no block follows the walk down.
//   The node memory has a single write port and a registered read port;
//   a granted request walks once down and once up the tree.
//   total_order must be written on cfg_valid/cfg_ready only while idle; the
//   block does not enforce it. A write clears the tree to one free root block
//   and zeroes both counters. Reset does the same with order 10 (capped at
//   MAX_ORDER); the root rewrite is the S_CLEAR state, during which in_stall is high.
// ---------------------------------------------------------------------------
module buddy_memory_allocator #(
  parameter int unsigned MAX_ORDER = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            opcode,
  input  logic [bma_pkg::ReqW-1:0]        request_size,
  input  logic [bma_pkg::AddrW-1:0]       block_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic [bma_pkg::AddrW-1:0]       granted_address,
  output logic [bma_pkg::ReqW-1:0]        granted_size,
  output logic [bma_pkg::CountW-1:0]      live_allocations,
  output logic [bma_pkg::DenyW-1:0]       denied_total,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bma_pkg::CfgW-1:0]        total_order
);

  localparam int unsigned NW = MAX_ORDER + 1;          // node index width
  localparam int unsigned MW = MAX_ORDER + 1;          // size mask width
  localparam int unsigned OW = $clog2(MAX_ORDER + 2);  // order width
  localparam int unsigned AW = MAX_ORDER;              // internal address
  localparam int unsigned Depth = 2 ** NW;

  typedef struct packed {
    bma_pkg::node_st_t st;
    logic [MW-1:0]     mask;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_ROOT, S_A_PICK, S_A_SPLIT,
    S_UP_WR, S_UP_CALC, S_F_DESC, S_RESP
  } state_t;

  function automatic logic [MW-1:0] size_bit(input logic [OW-1:0] o);
    size_bit = MW'(1) << o;
  endfunction

  function automatic logic [OW-1:0] clamp_order(input logic [bma_pkg::CfgW-1:0] v);
    logic [OW:0] ve;
    ve = (OW + 1)'(v);
    if (ve > (OW + 1)'(MAX_ORDER)) clamp_order = OW'(MAX_ORDER);
    else if (v == '0)              clamp_order = OW'(1);
    else                           clamp_order = OW'(v);
  endfunction

  state_t                      state;
  logic [OW-1:0]               tree_order;
  logic [bma_pkg::CountW-1:0]  live_count;
  logic [bma_pkg::DenyW-1:0]   denied_count;
  logic                        op;
  logic [OW-1:0]               want;
  logic [OW-1:0]               target;
  logic [OW-1:0]               ord;
  logic [NW-1:0]               node;
  logic [AW-1:0]               addr;
  entry_t                      cur_val;
  bma_pkg::status_t            res_status;
  logic [bma_pkg::ReqW-1:0]    res_size;

  // node memory
  entry_t                      mem [Depth];
  entry_t                      rd_a;
  logic                        we;
  logic [NW-1:0]               wa;
  entry_t                      wd;
  logic [NW-1:0]               ra;

  // request decode
  logic [bma_pkg::ReqW-1:0]    req_m1;
  logic [bma_pkg::WantW-1:0]   want_c;
  logic                        too_big;
  logic                        addr_out;
  logic                        k_found;
  logic [OW-1:0]               k_c;
  logic                        go_right;
  logic [NW-1:0]               pick;
  logic [NW-1:0]               f_child;
  logic [AW-1:0]               low_mask;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // round the request up to a power of two
  always_comb begin
    req_m1 = request_size - bma_pkg::ReqW'(1);
    want_c = '0;
    if (request_size > bma_pkg::ReqW'(1)) begin
      for (int j = 0; j < int'(bma_pkg::ReqW); j++) begin
        if (req_m1[j]) want_c = bma_pkg::WantW'(j + 1);
      end
    end
    too_big  = (5'(want_c) > 5'(tree_order));
    addr_out = ((32'(block_address) >> tree_order) != 32'd0);
  end

  // smallest free size at or above the wanted one, from the root mask
  always_comb begin
    k_found = 1'b0;
    k_c     = '0;
    for (int j = 0; j < int'(MW); j++) begin
      if (!k_found && rd_a.mask[j] && (OW'(j) >= want)) begin
        k_found = 1'b1;
        k_c     = OW'(j);
      end
    end
  end

  // descent choices
  always_comb begin
    go_right = !rd_a.mask[target];
    pick     = {node[NW-2:0], go_right};
    f_child  = {node[NW-2:0], addr[ord - OW'(1)]};
    low_mask = (AW'(1) << ord) - AW'(1);
  end

  // memory port control
  always_comb begin
    we = 1'b0;
    wa = node;
    wd = cur_val;
    ra = NW'(1);
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        wa = NW'(1);
        wd = '{st: bma_pkg::NODE_FREE, mask: size_bit(tree_order)};
      end
      S_A_ROOT: begin
        ra = NW'(2);
      end
      S_A_PICK: begin
        ra = {pick[NW-2:0], 1'b0};
      end
      S_A_SPLIT: begin
        if (ord != want) begin
          we = 1'b1;
          wa = {node[NW-2:0], 1'b1};
          wd = '{st: bma_pkg::NODE_FREE, mask: size_bit(ord - OW'(1))};
        end
      end
      S_UP_WR: begin
        we = 1'b1;
        ra = node ^ NW'(1);
      end
      S_F_DESC: begin
        ra = f_child;
      end
      default: begin
      end
    endcase
  end

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      tree_order   <= clamp_order(bma_pkg::CfgW'(bma_pkg::ResetOrder));
      live_count   <= '0;
      denied_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      // drop the taken result word unless a new one replaces it
      if (out_valid && !out_stall && (state != S_RESP || (cfg_valid && cfg_ready))) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        // register write clears the tree
        tree_order   <= clamp_order(total_order);
        live_count   <= '0;
        denied_count <= '0;
        state        <= S_CLEAR;
      end else begin
        case (state)
          S_CLEAR: begin
            state <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid) begin
              op   <= opcode;
              node <= NW'(1);
              ord  <= tree_order;
              if (!opcode) begin
                // allocate
                addr <= '0;
                want <= OW'(want_c);
                if (too_big) begin
                  if (denied_count != '1) denied_count <= denied_count + bma_pkg::DenyW'(1);
                  res_status <= bma_pkg::ST_NO_SPACE;
                  state      <= S_RESP;
                end else begin
                  state <= S_A_ROOT;
                end
              end else begin
                // free
                addr <= AW'(block_address);
                if (addr_out) begin
                  res_status <= bma_pkg::ST_NOT_FOUND;
                  state      <= S_RESP;
                end else begin
                  state <= S_F_DESC;
                end
              end
            end
          end
          S_A_ROOT: begin
            target <= k_c;
            if (!k_found) begin
              if (denied_count != '1) denied_count <= denied_count + bma_pkg::DenyW'(1);
              res_status <= bma_pkg::ST_NO_SPACE;
              state      <= S_RESP;
            end else if (k_c == tree_order) begin
              state <= S_A_SPLIT;
            end else begin
              state <= S_A_PICK;
            end
          end
          S_A_PICK: begin
            // advance to the child that holds the lowest free block of that size
            node <= pick;
            ord  <= ord - OW'(1);
            if (go_right) addr <= addr | (AW'(1) << (ord - OW'(1)));
            if ((ord - OW'(1)) == target) state <= S_A_SPLIT;
          end
          S_A_SPLIT: begin
            if (ord != want) begin
              node <= {node[NW-2:0], 1'b0};
              ord  <= ord - OW'(1);
            end else begin
              cur_val    <= '{st: bma_pkg::NODE_ALLOC, mask: '0};
              live_count <= live_count + bma_pkg::CountW'(1);
              res_status <= bma_pkg::ST_OK;
              res_size   <= bma_pkg::ReqW'(1) << want;
              state      <= S_UP_WR;
            end
          end
          S_UP_WR: begin
            if (node == NW'(1)) state <= S_RESP;
            else                state <= S_UP_CALC;
          end
          S_UP_CALC: begin
            // merge free buddies, else rebuild the parent mask
            if (cur_val.st == bma_pkg::NODE_FREE && rd_a.st == bma_pkg::NODE_FREE) begin
              cur_val <= '{st: bma_pkg::NODE_FREE, mask: size_bit(ord + OW'(1))};
            end else begin
              cur_val <= '{st: bma_pkg::NODE_SPLIT, mask: cur_val.mask | rd_a.mask};
            end
            node  <= node >> 1;
            ord   <= ord + OW'(1);
            state <= S_UP_WR;
          end
          S_F_DESC: begin
            if (rd_a.st == bma_pkg::NODE_SPLIT && ord != '0) begin
              node <= f_child;
              ord  <= ord - OW'(1);
            end else if (rd_a.st == bma_pkg::NODE_ALLOC && (addr & low_mask) == '0) begin
              cur_val    <= '{st: bma_pkg::NODE_FREE, mask: size_bit(ord)};
              if (live_count != '0) live_count <= live_count - bma_pkg::CountW'(1);
              res_status <= bma_pkg::ST_OK;
              res_size   <= bma_pkg::ReqW'(1) << ord;
              state      <= S_UP_WR;
            end else begin
              res_status <= bma_pkg::ST_NOT_FOUND;
              state      <= S_RESP;
            end
          end
          S_RESP: begin
            // present the result word once the output slot is free
            if (!out_valid || !out_stall) begin
              out_valid        <= 1'b1;
              status           <= res_status;
              live_allocations <= live_count;
              denied_total     <= denied_count;
              if (res_status == bma_pkg::ST_OK) begin
                granted_address <= bma_pkg::AddrW'(addr);
                granted_size    <= res_size;
              end else begin
                granted_address <= '0;
                granted_size    <= '0;
              end
              state <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  // checks
  a_up_not_root: assert property (@(posedge clk) disable iff (rst)
    state == S_UP_CALC |-> node != NW'(1))
    else $error("bubble step past root");

  a_split_right: assert property (@(posedge clk) disable iff (rst)
    (we && state == S_A_SPLIT) |-> wa[0])
    else $error("split wrote a left child");

  a_ok_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == bma_pkg::ST_OK) |-> granted_size != '0)
    else $error("ok result with zero size");

  a_free_only_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP_WR && op) |-> $past(state) == S_F_DESC || $past(state) == S_UP_CALC)
    else $error("free update not from descent");

endmodule
